// ----- sv/tdac_pkg.sv -----
package tdac_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register map
    localparam logic [3:0] ADDR_FIRST_LOCAL = 4'd4;
    localparam logic [3:0] ADDR_PAL_INDEX   = 4'd4;
    localparam logic [3:0] ADDR_PAL_DATA    = 4'd5;
    localparam logic [3:0] ADDR_ID_LOW      = 4'd6;
    localparam logic [3:0] ADDR_REV         = 4'd8;
    localparam logic [3:0] ADDR_ID_HIGH     = 4'd10;
    localparam logic [3:0] ADDR_MODE        = 4'd11;
    localparam logic [3:0] ADDR_DAC_CTRL    = 4'd12;
    localparam logic [3:0] ADDR_ID_TOP      = 4'd15;

    // fixed identification bytes
    localparam logic [7:0] RD_REV    = 8'h02;
    localparam logic [7:0] RD_ID     = 8'h1d;
    localparam logic [7:0] RD_ID_TOP = 8'hd0;
    localparam logic [7:0] RD_NONE   = 8'h00;

    // pixel modes
    localparam logic [2:0] MODE_4BPP  = 3'd0;
    localparam logic [2:0] MODE_8BPP  = 3'd1;
    localparam logic [2:0] MODE_15BPP = 3'd2;
    localparam logic [2:0] MODE_16BPP = 3'd3;
    localparam logic [2:0] MODE_24BPP = 3'd4;
    localparam logic [2:0] MODE_32BPP = 3'd5;
    localparam logic [2:0] MODE_ABGR  = 3'd6;
    localparam logic [2:0] MODE_RGBA  = 3'd7;

    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } tdac_wr_t;

    function automatic logic [2:0] decode_mode(input logic [7:0] v);
        logic [2:0] m;
        case (v)
            8'h82:        m = MODE_4BPP;
            8'h83:        m = MODE_8BPP;
            8'ha0, 8'hb0: m = MODE_15BPP;
            8'ha1, 8'hb1: m = MODE_16BPP;
            8'hc0, 8'hd0: m = MODE_24BPP;
            8'he2, 8'hf7: m = MODE_32BPP;
            8'he3:        m = MODE_ABGR;
            8'hf2:        m = MODE_RGBA;
            default:      m = MODE_8BPP;
        endcase
        return m;
    endfunction

    // six-bit dac: keep low six bits of each colour, times four
    function automatic logic [23:0] scale_color(input logic [23:0] raw, input logic six);
        logic [23:0] s;
        if (six) begin
            s = {raw[21:16], 2'b00, raw[13:8], 2'b00, raw[5:0], 2'b00};
        end else begin
            s = raw;
        end
        return s;
    endfunction

endpackage

// ----- sv/tdac_palette.sv -----
module tdac_palette
    import tdac_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  tdac_wr_t    wr,
    output logic [23:0] entry_zero,
    output logic [23:0] entry_one
);

    // only entries 0 and 1 are ever shown, so only those are kept
    localparam int KEPT = (PALETTE_ENTRIES > 1) ? 2 : 1;
    localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    logic [7:0]  index_reg, index_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic        store_en;
    logic [23:0] entry_reg [KEPT];

    always_comb begin
        index_next = index_reg;
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        store_en   = 1'b0;
        if (wr.en && wr.addr == ADDR_PAL_INDEX) begin
            index_next = wr.data;
            phase_next = PHASE_RED;
        end else if (wr.en && wr.addr == ADDR_PAL_DATA) begin
            case (phase_reg)
                PHASE_RED: begin
                    red_next   = wr.data;
                    phase_next = PHASE_GREEN;
                end
                PHASE_GREEN: begin
                    green_next = wr.data;
                    phase_next = PHASE_BLUE;
                end
                PHASE_BLUE: begin
                    // index past the palette: blue is dropped, phase stays
                    if ({1'b0, index_reg} < ENTRY_LIMIT) begin
                        store_en   = 1'b1;
                        phase_next = PHASE_RED;
                        index_next = index_reg + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            phase_reg <= PHASE_RED;
            red_reg   <= '0;
            green_reg <= '0;
        end else begin
            index_reg <= index_next;
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    for (genvar i = 0; i < KEPT; i++) begin : g_entry
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                entry_reg[i] <= '0;
            end else if (store_en && index_reg == 8'(i)) begin
                entry_reg[i] <= {red_reg, green_reg, wr.data};
            end
        end
    end

    assign entry_zero = entry_reg[0];

    if (KEPT > 1) begin : g_one
        assign entry_one = entry_reg[KEPT-1];
    end else begin : g_no_one
        assign entry_one = '0;
    end

endmodule

// ----- sv/truecolor_dac_register_block.sv -----
// Register block of a truecolor video DAC. Each input word is one bus access
// (s_tuser: 0 read, 1 write) to register 0..15; each gives exactly one result
// word in the cycle after it is taken, holding the read byte (0 for writes), the
// pixel mode, the six-bit DAC flag and palette entries 0 and 1 scaled for the
// current DAC width. A new word is taken every cycle; the only thing that
// holds s_tready low is a result word stalled by m_tready. The whole register
// update and read mux sits between the bus and the result register, so the
// throughput is one word per cycle when m_tready allows. Registers 0..3
// belong to the standard VGA DAC and read as 0 here.
module truecolor_dac_register_block
    import tdac_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [3:0] reg_addr, [11:4] write_data, [15:12] zero
    input  logic        s_tuser,  // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [10:8] pixel_mode, [11] six_bit_dac, [35:12] color_zero,
    // [59:36] color_one, [63:60] zero
    output logic [63:0] m_tdata
);

    logic        s_fire;
    logic [3:0]  addr;
    logic [7:0]  data;
    tdac_wr_t    wr;

    logic [7:0]  regs_reg [16];
    logic [2:0]  mode_reg;
    logic        six_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic        m_valid_reg;
    logic [23:0] entry_zero, entry_one;
    logic [23:0] color_zero, color_one;

    assign addr     = s_tdata[3:0];
    assign data     = s_tdata[11:4];
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign wr.en   = s_fire && s_tuser == OP_WRITE && addr >= ADDR_FIRST_LOCAL;
    assign wr.addr = addr;
    assign wr.data = data;

    tdac_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .entry_zero(entry_zero),
        .entry_one (entry_one)
    );

    always_comb begin
        read_data_next = RD_NONE;
        if (s_tuser == OP_READ && addr >= ADDR_FIRST_LOCAL) begin
            case (addr)
                ADDR_PAL_INDEX, ADDR_REV: read_data_next = RD_REV;
                ADDR_ID_LOW, ADDR_ID_HIGH: read_data_next = RD_ID;
                ADDR_ID_TOP:               read_data_next = RD_ID_TOP;
                default:                   read_data_next = regs_reg[addr];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                regs_reg[i] <= '0;
            end
            mode_reg      <= MODE_8BPP;
            six_reg       <= 1'b0;
            read_data_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (wr.en) begin
                regs_reg[addr] <= data;
                if (addr == ADDR_MODE) begin
                    mode_reg <= decode_mode(data);
                end
                if (addr == ADDR_DAC_CTRL) begin
                    six_reg <= data[0];
                end
            end
            if (s_fire) begin
                read_data_reg <= read_data_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // state only moves when a word is taken, and that only happens as the
    // previous result leaves, so the held result always matches the state
    assign color_zero = scale_color(entry_zero, six_reg);
    assign color_one  = scale_color(entry_one, six_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, color_one, color_zero, six_reg, mode_reg, read_data_reg};

    a_write_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == OP_WRITE |=> m_tdata[7:0] == RD_NONE)
        else $error("read byte not zero after a write");

    a_dac_ctrl_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == OP_WRITE && addr == ADDR_DAC_CTRL
        |=> m_tdata[11] == $past(s_tdata[4]))
        else $error("six-bit flag does not follow dac control write");

    a_six_bit_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        six_reg |-> color_zero[1:0] == 2'b00 && color_zero[9:8] == 2'b00
            && color_zero[17:16] == 2'b00 && color_one[1:0] == 2'b00
            && color_one[9:8] == 2'b00 && color_one[17:16] == 2'b00)
        else $error("six-bit colour has low bits set");

endmodule
